### design/php_pkg.sv
package php_pkg;

  localparam int MaxVlanDef = 2;
  localparam int MaxExtDef  = 4;

  localparam int NumRec     = 21;
  localparam int KindW      = 5;
  localparam int ValueW     = 64;
  localparam int TdataInW   = 8;
  localparam int TdataOutW  = 72;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_UNSUP_L3  = 2'd2,
    ST_UNSUP_L4  = 2'd3
  } status_t;

  typedef enum logic [KindW-1:0] {
    K_STATUS   = 5'd0,  K_LENGTH   = 5'd1,  K_ETYPE    = 5'd2,  K_VCOUNT   = 5'd3,
    K_TAG0     = 5'd4,  K_TAG1     = 5'd5,  K_IPVER    = 5'd6,  K_PROTO    = 5'd7,
    K_FRAGOFF  = 5'd8,  K_FRAGFLG  = 5'd9,  K_SPORT    = 5'd10, K_DPORT    = 5'd11,
    K_TCPFLG   = 5'd12, K_ICMP     = 5'd13, K_ARP      = 5'd14, K_IP4SRC   = 5'd15,
    K_IP4DST   = 5'd16, K_IP6SRCHI = 5'd17, K_IP6SRCLO = 5'd18, K_IP6DSTHI = 5'd19,
    K_IP6DSTLO = 5'd20
  } kind_t;

  // one frame's worth of results
  typedef struct packed {
    status_t     status;
    logic [15:0] length;
    logic [15:0] ethertype;
    logic [2:0]  vlan_count;
    logic [15:0] tag0;
    logic [15:0] tag1;
    logic [2:0]  ipver;
    logic [7:0]  proto;
    logic [12:0] fragoff;
    logic [1:0]  fragflags;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  tcpflags;
    logic [7:0]  icmp;
    logic [15:0] arp;
    logic [31:0] ip4src;
    logic [31:0] ip4dst;
    logic [63:0] ip6src_hi;
    logic [63:0] ip6src_lo;
    logic [63:0] ip6dst_hi;
    logic [63:0] ip6dst_lo;
  } hdr_rec_t;

  function automatic logic [ValueW-1:0] rec_value(hdr_rec_t r, logic [KindW-1:0] k);
    logic [ValueW-1:0] v;
    v = '0;
    unique case (k)
      K_STATUS:   v = 64'(r.status);
      K_LENGTH:   v = 64'(r.length);
      K_ETYPE:    v = 64'(r.ethertype);
      K_VCOUNT:   v = 64'(r.vlan_count);
      K_TAG0:     v = 64'(r.tag0);
      K_TAG1:     v = 64'(r.tag1);
      K_IPVER:    v = 64'(r.ipver);
      K_PROTO:    v = 64'(r.proto);
      K_FRAGOFF:  v = 64'(r.fragoff);
      K_FRAGFLG:  v = 64'(r.fragflags);
      K_SPORT:    v = 64'(r.sport);
      K_DPORT:    v = 64'(r.dport);
      K_TCPFLG:   v = 64'(r.tcpflags);
      K_ICMP:     v = 64'(r.icmp);
      K_ARP:      v = 64'(r.arp);
      K_IP4SRC:   v = 64'(r.ip4src);
      K_IP4DST:   v = 64'(r.ip4dst);
      K_IP6SRCHI: v = r.ip6src_hi;
      K_IP6SRCLO: v = r.ip6src_lo;
      K_IP6DSTHI: v = r.ip6dst_hi;
      K_IP6DSTLO: v = r.ip6dst_lo;
      default:    v = '0;
    endcase
    return v;
  endfunction

endpackage

### design/packet_header_parser.sv
// A frame's record set is written into the queue when its last byte is taken.
// Throughput: one frame byte per cycle while the queue is not full; each frame then
// drains as 21 records, one per cycle while m_tready is high, from a two-frame record
// queue, so frames under 21 bytes are paced by the record emitter.
// Reset: rst synchronous active high; clears parser state and the queue.
module packet_header_parser import php_pkg::*; #(
  parameter int MAX_VLAN = MaxVlanDef,
  parameter int MAX_EXT  = MaxExtDef
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [TdataInW-1:0]  s_tdata,   // [7:0] data_byte
  input  logic                 s_tlast,   // end_of_frame
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [TdataOutW-1:0] m_tdata,   // [4:0] record_kind, [68:5] record_value
  output logic                 m_tlast    // last_record
);

  logic     accept, push, pop, full, empty;
  hdr_rec_t push_rec, head;

  // Input request is taken whenever the queue can hold a finished frame.
  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  // Front: walks headers a byte per cycle while bytes are accepted, snapshots records on the last byte.
  php_front #(.MAX_VLAN(MAX_VLAN), .MAX_EXT(MAX_EXT)) u_front (
    .clk, .rst, .accept,
    .data_byte(s_tdata[7:0]), .end_of_frame(s_tlast),
    .push, .push_rec
  );

  // Queue of per-frame record sets decouples parse from drain.
  php_queue u_queue (
    .clk, .rst, .push, .push_rec, .pop, .full, .empty, .head
  );

  // Back: walks kinds 0..20 of the head frame.
  php_back u_back (
    .clk, .rst, .empty, .head, .pop,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

endmodule

### design/php_front.sv
module php_front import php_pkg::*; #(
  parameter int MAX_VLAN = MaxVlanDef,
  parameter int MAX_EXT  = MaxExtDef
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  logic [7:0] data_byte,
  input  logic     end_of_frame,
  output logic     push,
  output hdr_rec_t push_rec
);

  typedef enum logic [3:0] {
    PH_ETH, PH_VLAN, PH_ARP, PH_IP4, PH_IP6, PH_OPT, PH_AH, PH_FRAG,
    PH_TCP, PH_UDP, PH_ICMP, PH_DONE
  } phase_t;

  phase_t      phase, phase_n;
  status_t     status, status_n;
  logic [15:0] boff, boff_n, hstart, hstart_n, hend, hend_n;
  logic [7:0]  np, np_n;
  logic [3:0]  ext, ext_n;
  logic [2:0]  vcnt, vcnt_n;
  logic [15:0] tag [2];
  logic [15:0] tag_n [2];
  logic [63:0] addr [4];
  logic [63:0] addr_n [4];
  logic [15:0] s0, s0_n, s1, s1_n;
  logic [7:0]  s2, s2_n;
  logic [63:0] s3, s3_n;
  hdr_rec_t    rec, rec_n;

  always_comb begin
    logic [15:0] r, nb, len;
    logic [1:0]  idx;
    logic        chk, do_type, do_ext, do_l4, isf, first;
    logic [15:0] tval;
    logic [7:0]  l4p;
    phase_n = phase; status_n = status; hstart_n = hstart; hend_n = hend;
    np_n = np; ext_n = ext; vcnt_n = vcnt; tag_n = tag; addr_n = addr;
    s0_n = s0; s1_n = s1; s2_n = s2; s3_n = s3; rec_n = rec;
    r = boff - hstart;
    nb = boff + 16'd1;
    chk = 1'b1; do_type = 1'b0; do_ext = 1'b0; do_l4 = 1'b0;
    tval = s0; l4p = s2; isf = 1'b0; first = 1'b0; len = '0;
    idx = 2'(((r - 16'd8) >> 3));
    unique case (phase)
      PH_ETH: if (r == 16'd12 || r == 16'd13) s0_n = {s0[7:0], data_byte};
      PH_ARP: if (r == 16'd6 || r == 16'd7) s0_n = {s0[7:0], data_byte};
      PH_VLAN: begin
        if (r < 16'd2) s1_n = {s1[7:0], data_byte};
        else s0_n = {s0[7:0], data_byte};
      end
      PH_IP4: begin
        if (r == 16'd0) begin
          if (data_byte[7:4] != 4'd4) begin
            status_n = ST_MALFORMED; phase_n = PH_DONE; chk = 1'b0;
          end else begin
            s1_n = {10'd0, data_byte[3:0], 2'd0};
          end
        end else if (r == 16'd6 || r == 16'd7) begin
          s0_n = {s0[7:0], data_byte};
        end else if (r == 16'd9) begin
          s2_n = data_byte;
        end else if (r >= 16'd12 && r <= 16'd19) begin
          s3_n = {s3[55:0], data_byte};
        end
        if (r == 16'd19) begin
          if (s1_n < 16'd20) begin
            status_n = ST_MALFORMED; phase_n = PH_DONE; chk = 1'b0;
          end else begin
            hend_n = hstart + s1_n;
          end
        end
      end
      PH_IP6: begin
        if (r == 16'd0) begin
          if (data_byte[7:4] != 4'd6) begin
            status_n = ST_MALFORMED; phase_n = PH_DONE; chk = 1'b0;
          end else begin
            for (int i = 0; i < 4; i++) addr_n[i] = '0;
          end
        end else if (r == 16'd6) begin
          s2_n = data_byte;
        end else if (r >= 16'd8 && r < 16'd40) begin
          addr_n[idx] = {addr[idx][55:0], data_byte};
        end
      end
      PH_OPT, PH_AH: begin
        if (r == 16'd0) begin
          s2_n = data_byte;
        end else if (r == 16'd1) begin
          if (phase == PH_OPT) len = {4'd0, (9'(data_byte) + 9'd1), 3'd0};
          else len = {5'd0, (9'(data_byte) + 9'd2), 2'd0};
          hend_n = hstart + len;
        end
      end
      PH_FRAG: begin
        if (r == 16'd0) s2_n = data_byte;
        else if (r == 16'd2 || r == 16'd3) s0_n = {s0[7:0], data_byte};
      end
      PH_TCP, PH_UDP: begin
        if (r < 16'd2) s0_n = {s0[7:0], data_byte};
        else if (r < 16'd4) s1_n = {s1[7:0], data_byte};
        else if (phase == PH_TCP && r == 16'd12) s3_n = {58'd0, data_byte[7:4], 2'd0};
        else if (phase == PH_TCP && r == 16'd13) s2_n = data_byte;
        if (phase == PH_TCP && r == 16'd19) begin
          if (s3_n < 64'd20) begin
            status_n = ST_MALFORMED; phase_n = PH_DONE; chk = 1'b0;
          end else begin
            hend_n = hstart + s3_n[15:0];
          end
        end
      end
      PH_ICMP: if (r == 16'd0) s2_n = data_byte;
      default: chk = 1'b0;
    endcase

    // header complete: commit fields and pick the next header or end the parse
    if (chk && nb == hend_n) begin
      unique case (phase)
        PH_ETH: begin do_type = 1'b1; tval = s0_n; end
        PH_VLAN: begin
          if (vcnt < 3'd2) tag_n[vcnt[0]] = s1_n;
          vcnt_n = vcnt + 3'd1;
          rec_n.vlan_count = vcnt_n;
          rec_n.tag0 = tag_n[0];
          rec_n.tag1 = tag_n[1];
          do_type = 1'b1; tval = s0_n;
        end
        PH_ARP: begin rec_n.arp = s0_n; status_n = ST_OK; phase_n = PH_DONE; end
        PH_IP4: begin
          rec_n.ipver = 3'd4;
          rec_n.proto = s2_n;
          rec_n.ip4src = s3_n[63:32];
          rec_n.ip4dst = s3_n[31:0];
          rec_n.fragoff = s0_n[12:0];
          isf = |s0_n[13:0];
          first = isf && (s0_n[12:0] == 13'd0);
          rec_n.fragflags = {first, isf};
          if (isf && !first) begin
            status_n = ST_OK; phase_n = PH_DONE;
          end else begin
            do_l4 = 1'b1; l4p = s2_n;
          end
        end
        PH_IP6: begin
          rec_n.ipver = 3'd6;
          rec_n.ip6src_hi = addr_n[0];
          rec_n.ip6src_lo = addr_n[1];
          rec_n.ip6dst_hi = addr_n[2];
          rec_n.ip6dst_lo = addr_n[3];
          np_n = s2_n; ext_n = '0; do_ext = 1'b1;
        end
        PH_OPT, PH_AH: begin np_n = s2_n; ext_n = ext + 4'd1; do_ext = 1'b1; end
        PH_FRAG: begin
          np_n = s2_n; ext_n = ext + 4'd1;
          rec_n.fragoff = s0_n[15:3];
          first = (s0_n[15:3] == 13'd0);
          rec_n.fragflags = {first, 1'b1};
          if (!first) begin
            rec_n.proto = s2_n; status_n = ST_OK; phase_n = PH_DONE;
          end else begin
            do_ext = 1'b1;
          end
        end
        PH_TCP: begin
          rec_n.sport = s0_n; rec_n.dport = s1_n; rec_n.tcpflags = s2_n;
          status_n = ST_OK; phase_n = PH_DONE;
        end
        PH_UDP: begin
          rec_n.sport = s0_n; rec_n.dport = s1_n;
          status_n = ST_OK; phase_n = PH_DONE;
        end
        PH_ICMP: begin rec_n.icmp = s2_n; status_n = ST_OK; phase_n = PH_DONE; end
        default: ;
      endcase

      if (do_ext) begin
        if (ext_n >= 4'(MAX_EXT)) begin
          status_n = ST_UNSUP_L4; phase_n = PH_DONE;
        end else if (np_n == 8'd0 || np_n == 8'd43 || np_n == 8'd60) begin
          phase_n = PH_OPT; hstart_n = nb; hend_n = nb + 16'd2;
        end else if (np_n == 8'd51) begin
          phase_n = PH_AH; hstart_n = nb; hend_n = nb + 16'd2;
        end else if (np_n == 8'd44) begin
          phase_n = PH_FRAG; hstart_n = nb; hend_n = nb + 16'd8;
        end else begin
          rec_n.proto = np_n;
          if (rec_n.fragflags == 2'b01) begin
            status_n = ST_OK; phase_n = PH_DONE;
          end else begin
            do_l4 = 1'b1; l4p = np_n;
          end
        end
      end

      if (do_l4) begin
        if (l4p == 8'd6) begin
          phase_n = PH_TCP; hstart_n = nb; hend_n = nb + 16'd20;
        end else if (l4p == 8'd17) begin
          phase_n = PH_UDP; hstart_n = nb; hend_n = nb + 16'd8;
        end else if (l4p == 8'd1 || l4p == 8'd58) begin
          phase_n = PH_ICMP; hstart_n = nb; hend_n = nb + 16'd4;
        end else begin
          status_n = ST_UNSUP_L4; phase_n = PH_DONE;
        end
      end

      if (do_type) begin
        if ((tval == 16'h8100 || tval == 16'h88a8) && vcnt_n < 3'(MAX_VLAN)) begin
          phase_n = PH_VLAN; hstart_n = nb; hend_n = nb + 16'd4;
        end else begin
          rec_n.ethertype = tval;
          if (tval == 16'h0806) begin
            phase_n = PH_ARP; hstart_n = nb; hend_n = nb + 16'd8;
          end else if (tval == 16'h0800) begin
            phase_n = PH_IP4; hstart_n = nb; hend_n = nb + 16'd20;
          end else if (tval == 16'h86dd) begin
            phase_n = PH_IP6; hstart_n = nb; hend_n = nb + 16'd40;
          end else begin
            status_n = ST_UNSUP_L3; phase_n = PH_DONE;
          end
        end
      end
    end

    boff_n = (boff == 16'hffff) ? boff : nb;

    push_rec = rec_n;
    push_rec.status = (phase_n == PH_DONE) ? status_n : ST_MALFORMED;
    push_rec.length = boff_n;
  end

  assign push = accept && end_of_frame;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      phase <= PH_ETH; status <= ST_OK; boff <= '0; hstart <= '0; hend <= 16'd14;
      np <= '0; ext <= '0; vcnt <= '0; rec <= '0;
      s0 <= '0; s1 <= '0; s2 <= '0; s3 <= '0;
      for (int i = 0; i < 2; i++) tag[i] <= '0;
      for (int i = 0; i < 4; i++) addr[i] <= '0;
    end else if (accept) begin
      phase <= phase_n; status <= status_n; boff <= boff_n; hstart <= hstart_n;
      hend <= hend_n; np <= np_n; ext <= ext_n; vcnt <= vcnt_n; rec <= rec_n;
      s0 <= s0_n; s1 <= s1_n; s2 <= s2_n; s3 <= s3_n;
      tag <= tag_n; addr <= addr_n;
    end
  end

endmodule

### design/php_queue.sv
module php_queue import php_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  hdr_rec_t push_rec,
  input  logic     pop,
  output logic     full,
  output logic     empty,
  output hdr_rec_t head
);

  hdr_rec_t   mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0; rptr <= 1'b0; count <= '0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### design/php_back.sv
module php_back import php_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 empty,
  input  hdr_rec_t             head,
  output logic                 pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [TdataOutW-1:0] m_tdata,
  output logic                 m_tlast
);

  logic [KindW-1:0] kind;
  logic             is_last;

  assign is_last  = (kind == K_IP6DSTLO);
  assign m_tvalid = !empty;
  assign m_tlast  = is_last;
  assign m_tdata  = {3'd0, rec_value(head, kind), kind};
  assign pop      = m_tvalid && m_tready && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= K_STATUS;
    end else if (m_tvalid && m_tready) begin
      kind <= is_last ? K_STATUS : kind + 5'd1;
    end
  end

endmodule

### verif/tb_packet_header_parser.sv
module tb_packet_header_parser;
  import php_pkg::*;

  typedef enum int {
    P_ETH, P_VLAN, P_ARP, P_IP4, P_IP6, P_OPT, P_AH, P_FRAG, P_TCP, P_UDP, P_ICMP, P_DONE
  } phase_e;

  // Header walk that mirrors the parser and keeps the record queue it should emit.
  class hdr_scoreboard;
    logic [15:0] offs, hstart, hend;
    phase_e      phase;
    logic [7:0]  nxt;
    int          ext_cnt, vcnt;
    logic [15:0] tags[2];
    logic [63:0] addr[4], scr[4];
    status_t     status;
    logic [63:0] rec[NumRec];
    logic [KindW-1:0]  exp_kind[$];
    logic [ValueW-1:0] exp_val[$];
    bit                exp_last[$];
    int errors;

    function void clear();
      offs = 0; phase = P_ETH; hstart = 0; hend = 16'd14; nxt = 0;
      ext_cnt = 0; vcnt = 0; status = ST_OK;
      foreach (tags[i]) tags[i] = 0;
      foreach (addr[i]) addr[i] = 0;
      foreach (scr[i]) scr[i] = 0;
      foreach (rec[i]) rec[i] = 0;
    endfunction

    function void begin_hdr(phase_e ph, logic [15:0] len);
      phase = ph; hstart = offs + 16'd1; hend = hstart + len;
    endfunction

    function void finish(status_t st);
      status = st; phase = P_DONE;
    endfunction

    function void start_l4(logic [7:0] p);
      if (p == 8'd6) begin_hdr(P_TCP, 20);
      else if (p == 8'd17) begin_hdr(P_UDP, 8);
      else if (p == 8'd1 || p == 8'd58) begin_hdr(P_ICMP, 4);
      else finish(ST_UNSUP_L4);
    endfunction

    function void dispatch_type(logic [15:0] t);
      if ((t == 16'h8100 || t == 16'h88a8) && vcnt < MaxVlanDef) begin
        begin_hdr(P_VLAN, 4);
        return;
      end
      rec[K_ETYPE] = 64'(t);
      if (t == 16'h0806) begin_hdr(P_ARP, 8);
      else if (t == 16'h0800) begin_hdr(P_IP4, 20);
      else if (t == 16'h86dd) begin_hdr(P_IP6, 40);
      else finish(ST_UNSUP_L3);
    endfunction

    function void dispatch_ext();
      if (ext_cnt >= MaxExtDef) begin
        finish(ST_UNSUP_L4);
        return;
      end
      if (nxt == 8'd0 || nxt == 8'd43 || nxt == 8'd60) begin_hdr(P_OPT, 2);
      else if (nxt == 8'd51) begin_hdr(P_AH, 2);
      else if (nxt == 8'd44) begin_hdr(P_FRAG, 8);
      else begin
        rec[K_PROTO] = 64'(nxt);
        // non-first fragment: transport header is not in this packet
        if (rec[K_FRAGFLG][1:0] == 2'b01) finish(ST_OK);
        else start_l4(nxt);
      end
    endfunction

    function void complete_hdr();
      bit isf, first;
      case (phase)
        P_ETH: dispatch_type(scr[0][15:0]);
        P_VLAN: begin
          if (vcnt < 2) tags[vcnt] = scr[1][15:0];
          vcnt++;
          rec[K_VCOUNT] = 64'(vcnt);
          rec[K_TAG0] = 64'(tags[0]);
          rec[K_TAG1] = 64'(tags[1]);
          dispatch_type(scr[0][15:0]);
        end
        P_ARP: begin
          rec[K_ARP] = scr[0];
          finish(ST_OK);
        end
        P_IP4: begin
          rec[K_IPVER] = 4;
          rec[K_PROTO] = scr[2];
          rec[K_IP4SRC] = scr[3] >> 32;
          rec[K_IP4DST] = scr[3] & 64'hffff_ffff;
          rec[K_FRAGOFF] = scr[0] & 64'h1fff;
          isf = (scr[0] & 64'h3fff) != 0;
          first = isf && rec[K_FRAGOFF] == 0;
          rec[K_FRAGFLG] = {62'd0, first, isf};
          if (isf && !first) finish(ST_OK);
          else start_l4(scr[2][7:0]);
        end
        P_IP6: begin
          rec[K_IPVER] = 6;
          rec[K_IP6SRCHI] = addr[0];
          rec[K_IP6SRCLO] = addr[1];
          rec[K_IP6DSTHI] = addr[2];
          rec[K_IP6DSTLO] = addr[3];
          nxt = scr[2][7:0];
          ext_cnt = 0;
          dispatch_ext();
        end
        P_OPT, P_AH: begin
          nxt = scr[2][7:0];
          ext_cnt++;
          dispatch_ext();
        end
        P_FRAG: begin
          nxt = scr[2][7:0];
          ext_cnt++;
          rec[K_FRAGOFF] = (scr[0] & 64'hfff8) >> 3;
          first = rec[K_FRAGOFF] == 0;
          rec[K_FRAGFLG] = {62'd0, first, 1'b1};
          if (!first) begin
            rec[K_PROTO] = 64'(nxt);
            finish(ST_OK);
          end else begin
            dispatch_ext();
          end
        end
        P_TCP: begin
          rec[K_SPORT] = scr[0];
          rec[K_DPORT] = scr[1];
          rec[K_TCPFLG] = scr[2];
          finish(ST_OK);
        end
        P_UDP: begin
          rec[K_SPORT] = scr[0];
          rec[K_DPORT] = scr[1];
          finish(ST_OK);
        end
        P_ICMP: begin
          rec[K_ICMP] = scr[2];
          finish(ST_OK);
        end
        default: ;
      endcase
    endfunction

    function logic [63:0] sh16(logic [63:0] x, logic [7:0] b);
      return {48'd0, x[7:0], b};
    endfunction

    function void take_byte(logic [7:0] b);
      logic [15:0] r;
      int idx;
      logic [15:0] len;
      r = offs - hstart;
      case (phase)
        P_ETH: if (r == 12 || r == 13) scr[0] = sh16(scr[0], b);
        P_ARP: if (r == 6 || r == 7) scr[0] = sh16(scr[0], b);
        P_VLAN: begin
          if (r < 2) scr[1] = sh16(scr[1], b);
          else scr[0] = sh16(scr[0], b);
        end
        P_IP4: begin
          if (r == 0) begin
            if (b[7:4] != 4'd4) begin
              finish(ST_MALFORMED);
              return;
            end
            scr[1] = 64'(b[3:0]) * 4;
          end else if (r == 6 || r == 7) scr[0] = sh16(scr[0], b);
          else if (r == 9) scr[2] = 64'(b);
          else if (r >= 12 && r <= 19) scr[3] = {scr[3][55:0], b};
          if (r == 19) begin
            if (scr[1] < 20) begin
              finish(ST_MALFORMED);
              return;
            end
            hend = hstart + scr[1][15:0];
          end
        end
        P_IP6: begin
          if (r == 0) begin
            if (b[7:4] != 4'd6) begin
              finish(ST_MALFORMED);
              return;
            end
            foreach (addr[i]) addr[i] = 0;
          end else if (r == 6) scr[2] = 64'(b);
          else if (r >= 8 && r < 40) begin
            idx = ((r - 8) >> 3) & 3;
            addr[idx] = {addr[idx][55:0], b};
          end
        end
        P_OPT, P_AH: begin
          if (r == 0) scr[2] = 64'(b);
          else if (r == 1) begin
            len = (phase == P_OPT) ? (16'(b) + 16'd1) * 16'd8 : (16'(b) + 16'd2) * 16'd4;
            hend = hstart + len;
          end
        end
        P_FRAG: begin
          if (r == 0) scr[2] = 64'(b);
          else if (r == 2 || r == 3) scr[0] = sh16(scr[0], b);
        end
        P_TCP, P_UDP: begin
          if (r < 2) scr[0] = sh16(scr[0], b);
          else if (r < 4) scr[1] = sh16(scr[1], b);
          else if (phase == P_TCP && r == 12) scr[3] = 64'(b[7:4]) * 4;
          else if (phase == P_TCP && r == 13) scr[2] = 64'(b);
          if (phase == P_TCP && r == 19) begin
            if (scr[3] < 20) begin
              finish(ST_MALFORMED);
              return;
            end
            hend = hstart + scr[3][15:0];
          end
        end
        P_ICMP: if (r == 0) scr[2] = 64'(b);
        default: return;
      endcase
      if (offs + 16'd1 == hend) complete_hdr();
    endfunction

    // an accepted frame byte
    function void note_byte(logic [7:0] b, bit last);
      if (phase != P_DONE) take_byte(b);
      if (offs != 16'hffff) offs++;
      if (!last) return;
      // no complete parse by the final byte means a cut-off header
      rec[K_STATUS] = (phase == P_DONE) ? 64'(status) : 64'(ST_MALFORMED);
      rec[K_LENGTH] = 64'(offs);
      for (int k = 0; k < NumRec; k++) begin
        exp_kind.push_back(KindW'(k));
        exp_val.push_back(rec[k]);
        exp_last.push_back(k == NumRec - 1);
      end
      clear();
    endfunction

    // an accepted output record
    function void check(logic [TdataOutW-1:0] td, logic last);
      logic [KindW-1:0] k;
      logic [ValueW-1:0] v;
      bit l;
      if (exp_kind.size() == 0) begin
        $error("unexpected record kind %0d value %h", td[4:0], td[68:5]);
        errors++;
        return;
      end
      k = exp_kind.pop_front();
      v = exp_val.pop_front();
      l = exp_last.pop_front();
      if (td[4:0] !== k) begin
        $error("record_kind exp %0d got %0d", k, td[4:0]);
        errors++;
      end
      if (td[68:5] !== v) begin
        $error("record_value (kind %0d) exp %h got %h", k, v, td[68:5]);
        errors++;
      end
      if (last !== l) begin
        $error("last_record (kind %0d) exp %0d got %0d", k, l, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [TdataInW-1:0] s_tdata = '0;
  logic s_tlast = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [TdataOutW-1:0] m_tdata;
  logic m_tlast;

  hdr_scoreboard sb = new();
  logic [7:0] frame_q[$];
  bit calm = 0;       // no random idling on either side while set
  int stall_cycles = 0;

  packet_header_parser u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // watchdog: cycles with no request moving on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else if (!rst) stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 3000) begin
      $display("tb_packet_header_parser: errors");
      $finish;
    end
  end

  function automatic void push_rand(int n);
    for (int i = 0; i < n; i++) frame_q.push_back(8'($urandom));
  endfunction

  function automatic void push16(logic [15:0] v);
    frame_q.push_back(v[15:8]);
    frame_q.push_back(v[7:0]);
  endfunction

  function automatic logic [7:0] pick_l4();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'd6;
      3, 4, 5: return 8'd17;
      6:       return 8'd1;
      7:       return 8'd58;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void push_l4(logic [7:0] p);
    int doff;
    if (p == 8'd6) begin
      push_rand(12);
      doff = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 7);
      frame_q.push_back({4'(doff), 4'($urandom)});
      push_rand(7);
      if (doff > 5) push_rand(doff * 4 - 20);
    end else if (p == 8'd17) push_rand(8);
    else if (p == 8'd1 || p == 8'd58) push_rand(4);
  endfunction

  function automatic void push_ip4();
    int ihl;
    logic [7:0] p;
    ihl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 7);
    frame_q.push_back({($urandom_range(0, 19) == 0) ? 4'($urandom) : 4'd4, 4'(ihl)});
    push_rand(5);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: push16(($urandom_range(0, 1)) ? 16'h4000 : 16'h0000);
      6, 7:             push16(16'h2000);
      default:          push16(16'($urandom));
    endcase
    push_rand(1);
    p = pick_l4();
    frame_q.push_back(p);
    push_rand(10);
    if (ihl > 5) push_rand(ihl * 4 - 20);
    push_l4(p);
  endfunction

  function automatic void push_ip6();
    logic [7:0] ext_codes[5] = '{8'd0, 8'd43, 8'd60, 8'd51, 8'd44};
    logic [7:0] chain[$];
    logic [7:0] p, len;
    int n;
    n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
    for (int i = 0; i < n; i++) chain.push_back(ext_codes[$urandom_range(0, 4)]);
    p = pick_l4();
    chain.push_back(p);
    frame_q.push_back({($urandom_range(0, 19) == 0) ? 4'($urandom) : 4'd6, 4'($urandom)});
    push_rand(5);
    frame_q.push_back(chain[0]);
    push_rand(33);
    for (int i = 0; i < n; i++) begin
      frame_q.push_back(chain[i + 1]);
      len = 8'($urandom_range(0, 1));
      if (chain[i] == 8'd51) begin
        frame_q.push_back(len);
        push_rand((len + 2) * 4 - 2);
      end else if (chain[i] == 8'd44) begin
        push_rand(1);
        if ($urandom_range(0, 2) == 0) push16(16'($urandom));
        else push16({15'd0, 1'($urandom)});
        push_rand(4);
      end else begin
        frame_q.push_back(len);
        push_rand((len + 1) * 8 - 2);
      end
    end
    push_l4(p);
  endfunction

  function automatic void build_frame();
    int nv;
    frame_q = {};
    if ($urandom_range(0, 9) == 0) begin
      push_rand($urandom_range(1, 30));
      return;
    end
    push_rand(12);
    nv = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 3);
    for (int i = 0; i < nv; i++) begin
      push16($urandom_range(0, 1) ? 16'h8100 : 16'h88a8);
      push16(16'($urandom));
    end
    case ($urandom_range(0, 9))
      0: begin
        push16(16'h0806);
        push_rand(6);
        push16(16'($urandom));
      end
      1, 2, 3, 4: begin
        push16(16'h0800);
        push_ip4();
      end
      5, 6, 7, 8: begin
        push16(16'h86dd);
        push_ip6();
      end
      default: push16(16'($urandom));
    endcase
    push_rand($urandom_range(0, 6));
    // cut off somewhere inside
    if ($urandom_range(0, 6) == 0) frame_q = frame_q[0:$urandom_range(0, frame_q.size() - 1)];
  endfunction

  // frames follow each other with no forced gap; the caller drops valid at the end
  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) begin
      while (!calm && $urandom_range(0, 99) < 14) begin
        s_tvalid <= 0;
        @(posedge clk);
      end
      s_tvalid <= 1;
      s_tdata <= frame_q[i];
      s_tlast <= (i == frame_q.size() - 1);
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      sb.note_byte(frame_q[i], i == frame_q.size() - 1);
    end
  endtask

  // record sink: random backpressure plus one long hold-off
  initial begin
    int cyc;
    cyc = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check(m_tdata, m_tlast);
      cyc++;
      if (cyc == 150) begin
        m_tready <= 0;
        repeat (300) @(posedge clk);
      end
      m_tready <= calm || $urandom_range(0, 99) >= 14;
    end
  end

  initial begin
    int sent, nfr;
    sb.clear();
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // lone byte: header cut at once
    frame_q = '{8'hff};
    send_frame();
    // all-ones MACs, unknown ethertype
    frame_q = {};
    for (int i = 0; i < 12; i++) frame_q.push_back(8'hff);
    push16(16'h1234);
    send_frame();
    // minimal ARP
    frame_q = {};
    for (int i = 0; i < 12; i++) frame_q.push_back(8'h00);
    push16(16'h0806);
    push_rand(6);
    push16(16'h0001);
    send_frame();

    sent = 0;
    nfr = 0;
    while (sent < 310) begin
      build_frame();
      calm = (nfr >= 3 && nfr < 7);
      sent += frame_q.size();
      send_frame();
      nfr++;
    end
    calm = 0;
    s_tvalid <= 0;
    s_tlast <= 0;

    while (sb.exp_kind.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.exp_kind.size() == 0) begin
      $display("tb_packet_header_parser: clean");
    end else begin
      $display("tb_packet_header_parser: errors");
    end
    $finish;
  end

endmodule

### packet_header_parser.f
design/php_pkg.sv
design/php_front.sv
design/php_queue.sv
design/php_back.sv
design/packet_header_parser.sv
verif/tb_packet_header_parser.sv
